// File: rtl/crm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crm_pkg
// Shared constants, register codes and the queue item for the color range
// mask opening block.
// ----------------------------------------------------------------------------
package crm_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int WINDOW_SIZE = 3;

    localparam int WIN_BITS    = WINDOW_SIZE * WINDOW_SIZE;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    // rows keep counting a little past the frame while the last rows drain
    localparam int ROW_W       = $clog2(MAX_HEIGHT) + 2;
    localparam int DIM_W       = 11;
    localparam int DELAY_DEPTH = (WINDOW_SIZE - 1) * (MAX_WIDTH + 1);
    localparam int SLOT_W      = $clog2(DELAY_DEPTH);

    localparam int CHAN_W      = 8;
    localparam int PIXEL_W     = 3 * CHAN_W;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLUE_LOW     = 3'd0,
        REG_BLUE_HIGH    = 3'd1,
        REG_GREEN_LOW    = 3'd2,
        REG_GREEN_HIGH   = 3'd3,
        REG_RED_LOW      = 3'd4,
        REG_RED_HIGH     = 3'd5,
        REG_FRAME_WIDTH  = 3'd6,
        REG_FRAME_HEIGHT = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    // one classified item, front to back
    typedef struct packed {
        logic [PIXEL_W-1:0] color;      // zero for blank or drain slots
        logic               range_bit;
        logic [COL_W-1:0]   col;
        logic               col_first;
        logic               row_par;
        logic               anchor_ok;  // window lies fully inside the frame
        logic [SLOT_W-1:0]  slot;       // delay ring slot
        logic               emit;
        logic [COL_W-1:0]   ocol;
        logic               ocol_first;
        logic               orow_par;
        logic               orow_ge1;
        logic               orow_ge2;
        logic               frame_end;
    } crm_item_t;

endpackage
`default_nettype wire

// File: rtl/crm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crm_if
// Valid/ready channels of the color range mask opening block: pixel input,
// result output and register write.
// ----------------------------------------------------------------------------
interface crm_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [crm_pkg::CHAN_W-1:0]  blue;
    logic [crm_pkg::CHAN_W-1:0]  green;
    logic [crm_pkg::CHAN_W-1:0]  red;

    modport source (output valid, command, blue, green, red, input ready);
    modport sink   (input valid, command, blue, green, red, output ready);
endinterface

interface crm_out_if;
    logic                        valid;
    logic                        ready;
    logic [crm_pkg::CHAN_W-1:0]  out_blue;
    logic [crm_pkg::CHAN_W-1:0]  out_green;
    logic [crm_pkg::CHAN_W-1:0]  out_red;
    logic                        keep;
    logic                        frame_end;

    modport source (output valid, out_blue, out_green, out_red, keep, frame_end,
                    input ready);
    modport sink   (input valid, out_blue, out_green, out_red, keep, frame_end,
                    output ready);
endinterface

interface crm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [crm_pkg::CFG_IDX_W-1:0]  index;
    logic [crm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/crm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crm_front
// Register file, range test and frame position tracking; turns each accepted
// item into a queue entry.
// ----------------------------------------------------------------------------
module crm_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    crm_in_if.sink                pix_in,
    crm_cfg_if.sink               cfg,
    input  wire logic             fifo_full,
    output logic                  push,
    output crm_pkg::crm_item_t    push_item
);

    localparam int DIM_W = crm_pkg::DIM_W;
    localparam int COL_W = crm_pkg::COL_W;
    localparam int ROW_W = crm_pkg::ROW_W;
    localparam int SLOT_W = crm_pkg::SLOT_W;
    localparam int CHAN_W = crm_pkg::CHAN_W;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        res = v;
        if (v < DIM_W'(crm_pkg::WINDOW_SIZE))
            res = DIM_W'(crm_pkg::WINDOW_SIZE);
        else if (v > hi)
            res = hi;
        return res;
    endfunction

    // configuration
    logic [CHAN_W-1:0] blue_low_reg, blue_high_reg;
    logic [CHAN_W-1:0] green_low_reg, green_high_reg;
    logic [CHAN_W-1:0] red_low_reg, red_high_reg;
    logic [DIM_W-1:0]  frame_width_reg, frame_height_reg;

    // frame position
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  ocol_reg, ocol_next;
    logic [ROW_W-1:0]  orow_reg, orow_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              primed_reg, primed_next;
    logic              frame_start_reg;
    logic [DIM_W-1:0]  geo_w_reg, geo_h_reg;

    logic [DIM_W-1:0]  geo_w, geo_h, w_last, h_last;
    logic [SLOT_W-1:0] slot_last;
    logic              in_frame, in_range, is_pixel;
    logic              col_last, ocol_last, orow_last, fe;

    assign cfg.ready    = 1'b1;
    assign pix_in.ready = !fifo_full;
    assign push         = pix_in.valid && !fifo_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blue_low_reg     <= '0;
            blue_high_reg    <= '1;
            green_low_reg    <= '0;
            green_high_reg   <= '1;
            red_low_reg      <= '0;
            red_high_reg     <= '1;
            frame_width_reg  <= DIM_W'(640);
            frame_height_reg <= DIM_W'(480);
        end
        else if (cfg.valid)
        begin
            case (crm_pkg::cfg_reg_t'(cfg.index))
                crm_pkg::REG_BLUE_LOW:     blue_low_reg     <= cfg.data[CHAN_W-1:0];
                crm_pkg::REG_BLUE_HIGH:    blue_high_reg    <= cfg.data[CHAN_W-1:0];
                crm_pkg::REG_GREEN_LOW:    green_low_reg    <= cfg.data[CHAN_W-1:0];
                crm_pkg::REG_GREEN_HIGH:   green_high_reg   <= cfg.data[CHAN_W-1:0];
                crm_pkg::REG_RED_LOW:      red_low_reg      <= cfg.data[CHAN_W-1:0];
                crm_pkg::REG_RED_HIGH:     red_high_reg     <= cfg.data[CHAN_W-1:0];
                crm_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data[DIM_W-1:0];
                crm_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg.data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // geometry is sampled by the first item of a frame
    assign geo_w = frame_start_reg
                 ? clamp_dim(frame_width_reg, DIM_W'(crm_pkg::MAX_WIDTH)) : geo_w_reg;
    assign geo_h = frame_start_reg
                 ? clamp_dim(frame_height_reg, DIM_W'(crm_pkg::MAX_HEIGHT)) : geo_h_reg;
    assign w_last    = geo_w - DIM_W'(1);
    assign h_last    = geo_h - DIM_W'(1);
    assign slot_last = SLOT_W'({geo_w, 1'b0}) + SLOT_W'(1);   // 2w+2 slots

    assign in_frame  = row_reg < ROW_W'(geo_h);
    assign is_pixel  = (pix_in.command == crm_pkg::CMD_PIXEL) && in_frame;
    assign in_range  = (pix_in.blue  >= blue_low_reg)  && (pix_in.blue  <= blue_high_reg)
                    && (pix_in.green >= green_low_reg) && (pix_in.green <= green_high_reg)
                    && (pix_in.red   >= red_low_reg)   && (pix_in.red   <= red_high_reg);

    assign col_last  = DIM_W'(col_reg) == w_last;
    assign ocol_last = DIM_W'(ocol_reg) == w_last;
    assign orow_last = orow_reg == ROW_W'(h_last);
    assign fe        = primed_reg && ocol_last && orow_last;

    always_comb
    begin
        col_next    = col_last ? '0 : col_reg + COL_W'(1);
        row_next    = col_last ? row_reg + ROW_W'(1) : row_reg;
        slot_next   = (slot_reg == slot_last) ? '0 : slot_reg + SLOT_W'(1);
        primed_next = primed_reg || (slot_reg == slot_last);
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        if (primed_reg)
        begin
            ocol_next = ocol_last ? '0 : ocol_reg + COL_W'(1);
            orow_next = ocol_last ? orow_reg + ROW_W'(1) : orow_reg;
        end
        if (fe)
        begin
            col_next    = '0;
            row_next    = '0;
            ocol_next   = '0;
            orow_next   = '0;
            slot_next   = '0;
            primed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            ocol_reg        <= '0;
            orow_reg        <= '0;
            slot_reg        <= '0;
            primed_reg      <= 1'b0;
            frame_start_reg <= 1'b1;
            geo_w_reg       <= DIM_W'(crm_pkg::WINDOW_SIZE);
            geo_h_reg       <= DIM_W'(crm_pkg::WINDOW_SIZE);
        end
        else if (push)
        begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            ocol_reg        <= ocol_next;
            orow_reg        <= orow_next;
            slot_reg        <= slot_next;
            primed_reg      <= primed_next;
            frame_start_reg <= fe;
            geo_w_reg       <= geo_w;
            geo_h_reg       <= geo_h;
        end
    end

    always_comb
    begin
        push_item.color      = is_pixel ? {pix_in.red, pix_in.green, pix_in.blue} : '0;
        push_item.range_bit  = is_pixel && in_range;
        push_item.col        = col_reg;
        push_item.col_first  = col_reg == '0;
        push_item.row_par    = row_reg[0];
        push_item.anchor_ok  = (row_reg >= ROW_W'(crm_pkg::WINDOW_SIZE - 1))
                            && (col_reg >= COL_W'(crm_pkg::WINDOW_SIZE - 1));
        push_item.slot       = slot_reg;
        push_item.emit       = primed_reg;
        push_item.ocol       = ocol_reg;
        push_item.ocol_first = ocol_reg == '0;
        push_item.orow_par   = orow_reg[0];
        push_item.orow_ge1   = orow_reg >= ROW_W'(1);
        push_item.orow_ge2   = orow_reg >= ROW_W'(2);
        push_item.frame_end  = fe;
    end

endmodule
`default_nettype wire

// File: rtl/crm_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crm_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module crm_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire crm_pkg::crm_item_t push_item,
    input  wire logic               pop,
    output logic                    full,
    output logic                    empty,
    output crm_pkg::crm_item_t      pop_item
);

    localparam int AW = crm_pkg::FIFO_AW;

    crm_pkg::crm_item_t    entry_mem [crm_pkg::FIFO_DEPTH];
    logic [AW-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]           count_reg;

    assign full     = count_reg == (AW+1)'(crm_pkg::FIFO_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_item = entry_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            if (push && !pop)
                count_reg <= count_reg + (AW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (AW+1)'(1);
        end
    end

endmodule
`default_nettype wire

// File: rtl/crm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crm_back
// Line stores, 3x3 windows, pixel delay ring and the output register.
// ----------------------------------------------------------------------------
module crm_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fifo_empty,
    input  wire crm_pkg::crm_item_t fifo_item,
    output logic                    pop,
    crm_out_if.source               pix_out
);

    localparam int WB = crm_pkg::WIN_BITS;
    localparam int CHAN_W = crm_pkg::CHAN_W;

    logic                          range_bank0_mem  [crm_pkg::MAX_WIDTH];
    logic                          range_bank1_mem  [crm_pkg::MAX_WIDTH];
    logic                          anchor_bank0_mem [crm_pkg::MAX_WIDTH];
    logic                          anchor_bank1_mem [crm_pkg::MAX_WIDTH];
    logic [crm_pkg::PIXEL_W-1:0]   ring_mem         [crm_pkg::DELAY_DEPTH];

    // read stage
    logic                          s1_valid_reg;
    crm_pkg::crm_item_t            s1_item_reg;
    logic                          range_rd0_reg, range_rd1_reg;
    logic                          anchor_rd0_reg, anchor_rd1_reg;
    logic [crm_pkg::PIXEL_W-1:0]   ring_rd_reg;

    // window state and output register
    logic [WB-1:0]                 range_win_reg, range_win_next;
    logic [WB-1:0]                 anchor_win_reg, anchor_win_next;
    logic                          out_valid_reg;
    logic [crm_pkg::PIXEL_W-1:0]   out_color_reg;
    logic                          keep_reg, frame_end_reg;

    logic advance, anchor_we, anchor_bit, old_two, old_one, a2, a1;

    assign advance   = !out_valid_reg || pix_out.ready;
    assign pop       = advance && !fifo_empty;
    assign anchor_we = advance && s1_valid_reg && s1_item_reg.emit;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_item_reg    <= fifo_item;
            range_rd0_reg  <= range_bank0_mem[fifo_item.col];
            range_rd1_reg  <= range_bank1_mem[fifo_item.col];
            if (fifo_item.row_par)
                range_bank1_mem[fifo_item.col] <= fifo_item.range_bit;
            else
                range_bank0_mem[fifo_item.col] <= fifo_item.range_bit;
            ring_rd_reg    <= ring_mem[fifo_item.slot];
            ring_mem[fifo_item.slot] <= fifo_item.color;
            anchor_rd0_reg <= anchor_bank0_mem[fifo_item.ocol];
            anchor_rd1_reg <= anchor_bank1_mem[fifo_item.ocol];
        end
        if (anchor_we)
        begin
            if (s1_item_reg.orow_par)
                anchor_bank1_mem[s1_item_reg.ocol] <= anchor_bit;
            else
                anchor_bank0_mem[s1_item_reg.ocol] <= anchor_bit;
        end
    end

    // bank picked by row parity holds row r-2, the other row r-1
    always_comb
    begin
        old_two = s1_item_reg.row_par ? range_rd1_reg : range_rd0_reg;
        old_one = s1_item_reg.row_par ? range_rd0_reg : range_rd1_reg;
        range_win_next = {(s1_item_reg.col_first ? 6'b0 : range_win_reg[5:0]),
                          old_two, old_one, s1_item_reg.range_bit};
        anchor_bit = (&range_win_next) && s1_item_reg.anchor_ok;

        a2 = s1_item_reg.orow_ge2
           && (s1_item_reg.orow_par ? anchor_rd1_reg : anchor_rd0_reg);
        a1 = s1_item_reg.orow_ge1
           && (s1_item_reg.orow_par ? anchor_rd0_reg : anchor_rd1_reg);
        anchor_win_next = {(s1_item_reg.ocol_first ? 6'b0 : anchor_win_reg[5:0]),
                           a2, a1, anchor_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            range_win_reg  <= '0;
            anchor_win_reg <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= !fifo_empty;
            out_valid_reg <= s1_valid_reg && s1_item_reg.emit;
            if (s1_valid_reg)
                range_win_reg <= range_win_next;
            if (anchor_we)
                anchor_win_reg <= anchor_win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (anchor_we)
        begin
            out_color_reg <= ring_rd_reg;
            keep_reg      <= |anchor_win_next;
            frame_end_reg <= s1_item_reg.frame_end;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_blue  = out_color_reg[CHAN_W-1:0];
    assign pix_out.out_green = out_color_reg[2*CHAN_W-1:CHAN_W];
    assign pix_out.out_red   = out_color_reg[3*CHAN_W-1:2*CHAN_W];
    assign pix_out.keep      = keep_reg;
    assign pix_out.frame_end = frame_end_reg;

endmodule
`default_nettype wire

// File: rtl/color_range_mask_opening_core.sv
// Throughput: one item per clock unless a side stalls; either may stall.
// Latency: a pixel leaves as the result of the item that enters 2*width+2
//   items after it; that item passes the queue, read stage, output register.
// Reset: registers back to defaults, counters and windows cleared; the line
//   stores and the delay ring need no clearing pass, every entry is written
//   before a result depends on it.
`default_nettype none
// ----------------------------------------------------------------------------
// color_range_mask_opening_core
// BGR pixel stream in raster order; each pixel is tested against six channel
// limits and the resulting mask is opened with a 3x3 window (erode, then
// dilate). Pixels leave two rows and two pixels later with a keep flag.
// ----------------------------------------------------------------------------
module color_range_mask_opening_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    crm_in_if.sink      pix_in,
    crm_out_if.source   pix_out,
    crm_cfg_if.sink     cfg
);

    // Front: holds the register file, tests the pixel against the limits and
    // tracks both the input and the output positions in the frame. Geometry is
    // sampled by the first item of each frame, so a write mid-frame applies to
    // the next one. Once all pixels of a frame are in, any item is a flush.
    logic               push;
    crm_pkg::crm_item_t push_item;

    // Queue: a few entries, lets the front keep taking items while the output
    // register is stalled.
    logic               pop;
    logic               fifo_full, fifo_empty;
    crm_pkg::crm_item_t pop_item;

    crm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .cfg       (cfg),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    crm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (fifo_full),
        .empty     (fifo_empty),
        .pop_item  (pop_item)
    );

    // Back: one read stage (two range-bit line stores, two anchor-bit line
    // stores, the pixel delay ring, all read-first) and the output register.
    // A range window with all nine bits set inside the frame marks an anchor;
    // the anchor window, kept in output coordinates, gives keep when any anchor
    // covers the pixel. The whole back advances as one when the output is free.
    crm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_item  (pop_item),
        .pop        (pop),
        .pix_out    (pix_out)
    );

`ifndef NO_ASSERTIONS
    // front never writes a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_full)
        else $error("item pushed into full queue");

    // frame end is only ever flagged on an item that produces a result
    a_fe_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_item.frame_end) |-> push_item.emit)
        else $error("frame end on an item with no result");

    // queue status flags are consistent
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_full && fifo_empty))
        else $error("queue both full and empty");

    // after a frame end is queued, the next queued item starts the frame
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_item.frame_end) |=> (!push || (!push_item.emit
            && push_item.col_first && push_item.slot == '0)))
        else $error("frame did not restart after frame end");
`endif

endmodule
`default_nettype wire
